### hdl/csrmv_pkg.sv
// Shared types and constants for the sparse CSR matrix-vector multiply block.
package csrmv_pkg;

  // Request codes carried on the input tuser field
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_MAC   = 2'd1;
  localparam logic [1:0] REQ_EMPTY = 2'd2;

  localparam int INDEX_W = 12;
  localparam int VALUE_W = 32;
  localparam int VLEN_W  = 13;
  localparam int ROWNUM_W = 16;
  localparam int ACC_W   = 64;
  localparam int FRAC_W  = 16;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd4096;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Command queue between front and back
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               bad;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  row_sum;
    logic [ROWNUM_W-1:0] row_number;
    logic                overflow;
    logic                bad_column;
  } res_t;

endpackage

### hdl/csrmv_front.sv
// Front end: holds vector_length, classifies input items into queue commands.
module csrmv_front import csrmv_pkg::*; #(
  parameter int VECTOR_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [VLEN_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [INDEX_W-1:0] in_index,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  logic [VLEN_W-1:0] vlen_r;
  logic [VLEN_W-1:0] vlen_nxt;
  logic [31:0]       idx_ext;
  logic              in_store;
  logic              keep;
  op_t               op;

  assign cfg_ready = 1'b1;
  assign vlen_nxt  = (cfg_valid && cfg_ready) ? cfg_data : vlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_RESET;
    end else begin
      vlen_r <= vlen_nxt;
    end
  end

  assign idx_ext  = 32'(in_index);
  assign in_store = idx_ext < 32'(VECTOR_DEPTH);

  // Decode request kind; drop loads beyond the store and unused codes
  always_comb begin
    unique case (in_req_type)
      REQ_LOAD: begin
        op   = OP_LOAD;
        keep = in_store;
      end
      REQ_MAC: begin
        op   = OP_MAC;
        keep = 1'b1;
      end
      REQ_EMPTY: begin
        op   = OP_EMPTY;
        keep = 1'b1;
      end
      default: begin
        op   = OP_EMPTY;
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full && keep;
  assign q_cmd.op    = op;
  assign q_cmd.index = in_index;
  assign q_cmd.value = in_value;
  assign q_cmd.bad   = ({1'b0, in_index} >= vlen_r) || !in_store;
  assign q_cmd.last  = in_last;

endmodule

### hdl/csrmv_fifo.sv
// Short command queue decoupling the front end from the back end.
module csrmv_fifo import csrmv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty,
  output logic full
);

  cmd_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_nxt;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/csrmv_back.sv
// Back end: vector store, multiply, saturating row accumulate, result register.
module csrmv_back import csrmv_pkg::*; #(
  parameter int VECTOR_DEPTH   = 4096,
  parameter int ROW_COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  output logic q_pop,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic [VALUE_W-1:0] mem [VECTOR_DEPTH];

  logic        advance;
  logic [31:0] idx_ext;
  logic [AW-1:0] addr;

  // Stage A: store read
  logic               a_valid_r;
  op_t                a_op_r;
  logic [VALUE_W-1:0] a_value_r;
  logic               a_bad_r;
  logic               a_last_r;
  logic [VALUE_W-1:0] rd_data_r;

  // Stage B: product
  logic               b_valid_r;
  op_t                b_op_r;
  logic               b_bad_r;
  logic               b_last_r;
  logic signed [ACC_W-1:0] b_prod_r;
  logic signed [ACC_W-1:0] prod;

  // Stage C: accumulate
  logic [ACC_W-1:0]          acc_r;
  logic [ACC_W-1:0]          acc_nxt;
  logic                      sat_r;
  logic                      sat_nxt;
  logic                      bad_r;
  logic                      bad_nxt;
  logic [ROW_COUNT_BITS-1:0] row_cnt_r;
  logic [ROW_COUNT_BITS-1:0] row_cnt_nxt;
  logic [ACC_W-1:0]          addend;
  logic [ACC_W-1:0]          sum;
  logic                      add_ovf;
  logic [ACC_W-1:0]          new_acc;
  logic                      new_sat;
  logic                      new_bad;
  logic                      finish;
  logic [31:0]               row_ext;

  // Stage D: finished row
  logic                 res_valid_r;
  logic [ACC_W-1:0]     res_acc_r;
  logic                 res_sat_r;
  logic                 res_bad_r;
  logic [ROWNUM_W-1:0]  res_row_r;
  logic                 in_range;
  res_t                 res_clamped;

  // Output register
  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;

  // Freeze the whole pipe while a result waits at the output
  assign advance = !(out_valid_r && !out_ready);
  assign q_pop   = advance && !q_empty;
  assign idx_ext = 32'(q_cmd.index);
  assign addr    = idx_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == OP_LOAD) begin
      mem[addr] <= q_cmd.value;
    end
    if (q_pop && q_cmd.op == OP_MAC && !q_cmd.bad) begin
      rd_data_r <= mem[addr];
    end
  end

  assign prod = $signed(a_value_r) * $signed(rd_data_r);

  always_comb begin
    if (b_op_r == OP_MAC && !b_bad_r) begin
      addend = {{FRAC_W{b_prod_r[ACC_W-1]}}, b_prod_r[ACC_W-1:FRAC_W]};
    end else begin
      addend = '0;
    end
    sum     = acc_r + addend;
    add_ovf = (acc_r[ACC_W-1] == addend[ACC_W-1]) && (sum[ACC_W-1] != acc_r[ACC_W-1]);
    new_acc = add_ovf ? (acc_r[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
    new_sat = sat_r || add_ovf;
    new_bad = bad_r || (b_op_r == OP_MAC && b_bad_r);
    finish  = b_valid_r && ((b_op_r == OP_MAC && b_last_r) || b_op_r == OP_EMPTY);

    acc_nxt     = acc_r;
    sat_nxt     = sat_r;
    bad_nxt     = bad_r;
    row_cnt_nxt = row_cnt_r;
    if (advance && b_valid_r) begin
      if (finish) begin
        acc_nxt     = '0;
        sat_nxt     = 1'b0;
        bad_nxt     = 1'b0;
        row_cnt_nxt = row_cnt_r + 1'b1;
      end else begin
        acc_nxt = new_acc;
        sat_nxt = new_sat;
        bad_nxt = new_bad;
      end
    end
  end

  assign row_ext = 32'(row_cnt_r);

  // Clamp the finished row sum to 32 bits
  always_comb begin
    in_range = (&res_acc_r[ACC_W-1:VALUE_W-1]) || !(|res_acc_r[ACC_W-1:VALUE_W-1]);
    if (in_range) begin
      res_clamped.row_sum = res_acc_r[VALUE_W-1:0];
    end else begin
      res_clamped.row_sum = res_acc_r[ACC_W-1] ? SUM_MIN : SUM_MAX;
    end
    res_clamped.row_number = res_row_r;
    res_clamped.overflow   = res_sat_r || !in_range;
    res_clamped.bad_column = res_bad_r;
  end

  assign out_valid_nxt = advance ? res_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      bad_r       <= 1'b0;
      row_cnt_r   <= '0;
    end else begin
      if (advance) begin
        a_valid_r   <= q_pop && q_cmd.op != OP_LOAD;
        b_valid_r   <= a_valid_r;
        res_valid_r <= finish;
      end
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      bad_r       <= bad_nxt;
      row_cnt_r   <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_op_r    <= q_cmd.op;
      a_value_r <= q_cmd.value;
      a_bad_r   <= q_cmd.bad;
      a_last_r  <= q_cmd.last;
      b_op_r    <= a_op_r;
      b_bad_r   <= a_bad_r;
      b_last_r  <= a_last_r;
      b_prod_r  <= prod;
      if (finish) begin
        res_acc_r <= new_acc;
        res_sat_r <= new_sat;
        res_bad_r <= new_bad;
        res_row_r <= row_ext[ROWNUM_W-1:0];
      end
      if (res_valid_r) begin
        out_res_r <= res_clamped;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### hdl/sparse_csr_matrix_vector_multiply.sv
// A row-finishing item is written into the command queue at the edge that accepts it, then passes
// store read, multiply, accumulate and clamp into the output register, which raises out_tvalid.
// Throughput: one item per cycle while the command queue has room; the four-entry command queue
// and the single multiply-accumulate chain set that figure; output backpressure stalls the back end.
// Reset (rst_n low, synchronous): queue, pipeline valids, accumulator, flags and row
// counter clear; vector_length returns to 4096; the vector store keeps its contents.
module sparse_csr_matrix_vector_multiply import csrmv_pkg::*; #(
  parameter int VECTOR_DEPTH   = 4096,
  parameter int ROW_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: vector_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [11:0] index, [43:12] value, [47:44] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic        in_tlast,   // row_end
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] row_sum, [47:32] row_number
  output logic [1:0]  out_tuser   // [0] overflow, [1] bad_column
);

  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  cmd_t push_cmd;
  cmd_t pop_cmd;
  res_t res;

  // Classify items and hold the vector length register
  csrmv_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_req_type (in_tuser),
    .in_index    (in_tdata[11:0]),
    .in_value    (in_tdata[43:12]),
    .in_last     (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  // Buffer commands so the front keeps accepting while the back stalls, until the queue fills
  csrmv_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Execute loads and multiply-accumulates, emit finished rows
  csrmv_back #(
    .VECTOR_DEPTH   (VECTOR_DEPTH),
    .ROW_COUNT_BITS (ROW_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result fields onto the stream
  assign out_tdata = {res.row_number, res.row_sum};
  assign out_tuser = {res.bad_column, res.overflow};

endmodule

### hdl/csrmv_checker.sv
// Port-level checker for the sparse CSR matrix-vector multiply block, with its bind.
module csrmv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Reset empties the command queue, so input is taken right after
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("in_tready low after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind sparse_csr_matrix_vector_multiply csrmv_checker u_csrmv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### bench/sparse_csr_matrix_vector_multiply_test.sv
// Self-checking bench for the sparse CSR matrix-vector multiply block.
`timescale 1ns / 100ps

module sparse_csr_matrix_vector_multiply_test;
  import csrmv_pkg::*;

  // Request code the block must drop without any effect
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STORE_DEPTH  = 4096;
  // Cycles to let pass after the last expected row, enough to cover the
  // pipeline plus the command queue with margin
  localparam int DRAIN_CYCLES = 16;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [11:0] index, [43:12] value, [47:44] zero
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        in_tlast;   // row_end
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [31:0] row_sum, [47:32] row_number
  logic [1:0]  out_tuser;  // [0] overflow, [1] bad_column

  // Prediction state: mirrors the block's vector store, row accumulator,
  // row counter, per-row flags and the vector_length register
  logic [31:0]        vec_entries [STORE_DEPTH];
  longint             row_acc;
  logic               acc_saturated;
  logic               row_bad;
  logic [15:0]        rows_done;
  logic [VLEN_W-1:0]  model_length;
  res_t               pending_rows [$];

  // Stimulus-side bookkeeping: which store entries hold data, so that no
  // in-range column ever reads an entry that was never loaded
  bit                 loaded [STORE_DEPTH];
  int                 loaded_list [$];
  logic [VLEN_W-1:0]  stim_length;

  // Idle control for both sides
  int  gap_pct;
  int  stall_pct;
  bit  quiet;
  int  stall_left;
  int  errors;

  sparse_csr_matrix_vector_multiply dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Close the current row: clamp the 64-bit sum into Q16.16 and queue it
  task automatic finish_row;
    res_t row;
    begin
      row.overflow   = acc_saturated;
      row.bad_column = row_bad;
      row.row_number = rows_done;
      if (row_acc > 64'sd2147483647) begin
        row.row_sum  = SUM_MAX;
        row.overflow = 1'b1;
      end else if (row_acc < -64'sd2147483648) begin
        row.row_sum  = SUM_MIN;
        row.overflow = 1'b1;
      end else begin
        row.row_sum = row_acc[31:0];
      end
      pending_rows.push_back(row);
      row_acc       = 0;
      acc_saturated = 1'b0;
      row_bad       = 1'b0;
      rows_done     = rows_done + 16'd1;
    end
  endtask

  // Apply one accepted transaction to the prediction state
  task automatic predict_request(input logic [1:0] kind, input logic [11:0] idx,
                                 input logic [31:0] val, input logic last);
    longint lhs;
    longint rhs;
    longint term;
    longint sum;
    begin
      case (kind)
        REQ_LOAD: begin
          vec_entries[idx] = val;
        end
        REQ_MAC: begin
          if ({1'b0, idx} >= model_length) begin
            row_bad = 1'b1;
          end else begin
            lhs  = $signed(val);
            rhs  = $signed(vec_entries[idx]);
            // Arithmetic shift rounds toward minus infinity, as the block does
            term = (lhs * rhs) >>> FRAC_W;
            sum  = row_acc + term;
            if (row_acc[63] == term[63] && sum[63] != row_acc[63]) begin
              row_acc       = term[63] ? ACC_MIN : ACC_MAX;
              acc_saturated = 1'b1;
            end else begin
              row_acc = sum;
            end
          end
          if (last) finish_row();
        end
        REQ_EMPTY: begin
          finish_row();
        end
        default: begin
          // unused code: no result, no state change
        end
      endcase
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      errors++;
    end
  endtask

  // Sample both channels at the rising edge: predict from accepted input
  // transactions, compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) model_length = cfg_data;
      if (in_tvalid && in_tready)
        predict_request(in_tuser, in_tdata[11:0], in_tdata[43:12], in_tlast);
      if (out_tvalid && out_tready) begin
        if (pending_rows.size() == 0) begin
          $display("%0t: row result with none expected, expected none, actual sum %h row %h",
                   $time, out_tdata[31:0], out_tdata[47:32]);
          errors++;
        end else begin
          want = pending_rows.pop_front();
          report_field("row_sum", want.row_sum, out_tdata[31:0]);
          report_field("row_number", 32'(want.row_number), 32'(out_tdata[47:32]));
          report_field("overflow", 32'(want.overflow), 32'(out_tuser[0]));
          report_field("bad_column", 32'(want.bad_column), 32'(out_tuser[1]));
        end
      end
    end
  end

  // Result-side backpressure: drop ready for bursts of random length
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!quiet && stall_left == 0 && $urandom_range(99) < stall_pct)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Present one input transaction and hold it until the block takes it;
  // valid stays high into the next item unless a gap is inserted
  task automatic send_item(input logic [1:0] kind, input logic [11:0] idx,
                           input logic [31:0] val, input logic last);
    int gap;
    begin
      @(negedge clk);
      if (!quiet && $urandom_range(99) < gap_pct) begin
        gap = $urandom_range(1, 6);
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tuser  = kind;
      in_tdata  = {4'b0, val, idx};
      in_tlast  = last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [11:0] idx, input logic [31:0] val,
                            input logic last);
    send_item(REQ_LOAD, idx, val, last);
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(int'(idx));
    end
  endtask

  // Drop valid, wait for every predicted row, then let the pipeline empty
  task automatic settle;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vector_length(input logic [12:0] len);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    stim_length = len;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mix of full-range, small fractional, small integer and extreme Q16.16 values
  function automatic logic [31:0] random_q16();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0006_0000) - 32'h0003_0000;
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return ($urandom_range(16) - 8) << FRAC_W;
    endcase
  endfunction

  // Choose a column: out of range when asked and possible, else a loaded entry
  function automatic logic [11:0] pick_column(input bit want_bad);
    int pick;
    if (stim_length == 0) return 12'($urandom_range(4095));
    if (want_bad && stim_length < STORE_DEPTH) return 12'($urandom_range(4095, stim_length));
    for (int t = 0; t < 8; t++) begin
      pick = loaded_list[$urandom_range(loaded_list.size() - 1)];
      if (pick < stim_length) return 12'(pick);
    end
    // entry zero is loaded first and is in range whenever the length is nonzero
    return 12'd0;
  endfunction

  // Mostly well-formed rows with random content, plus loads, empty rows,
  // rows closed by an empty-row item and ignored noise
  task automatic stream_rows(input int n_items);
    int sent;
    int r;
    int len;
    logic [11:0] idx;
    begin
      sent = 0;
      while (sent < n_items) begin
        r = $urandom_range(99);
        if (r < 6) begin
          send_item(REQ_UNUSED, 12'($urandom_range(4095)), $urandom, 1'($urandom_range(1)));
        end else if (r < 16) begin
          if ($urandom_range(1) && stim_length > 0 && stim_length < STORE_DEPTH)
            idx = 12'($urandom_range(stim_length - 1));
          else
            idx = 12'($urandom_range(4095));
          load_entry(idx, random_q16(), 1'($urandom_range(1)));
          sent++;
        end else if (r < 22) begin
          send_item(REQ_EMPTY, 12'($urandom_range(4095)), $urandom, 1'($urandom_range(1)));
          sent++;
        end else if (r < 30) begin
          // nonzeros without a row end mark, closed by an empty-row item
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++)
            send_item(REQ_MAC, pick_column($urandom_range(99) < 10), random_q16(), 1'b0);
          send_item(REQ_EMPTY, 12'($urandom_range(4095)), $urandom, 1'($urandom_range(1)));
          sent += len + 1;
        end else begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++)
            send_item(REQ_MAC, pick_column($urandom_range(99) < 10), random_q16(),
                      k == len - 1);
          sent += len;
        end
      end
    end
  endtask

  // Store extremes, each request code, clamping both ways, rounding of a
  // negative product, the ignored code and the ignored row end on a load
  task automatic test_directed_requests;
    load_entry(12'd0, 32'h0001_0000, 1'b0);     // 1.0
    load_entry(12'd4095, 32'h8000_0000, 1'b1);  // row end mark on a load: drop it
    load_entry(12'd1, 32'h7FFF_FFFF, 1'b0);
    load_entry(12'd2, 32'h0000_0001, 1'b0);     // one LSB
    send_item(REQ_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(REQ_EMPTY, 12'd0, 32'd0, 1'b0);   // nothing pending: zero
    send_item(REQ_MAC, 12'd0, 32'h0002_0000, 1'b0);
    send_item(REQ_MAC, 12'd4095, 32'h0000_0001, 1'b1);
    send_item(REQ_MAC, 12'd4095, 32'h8000_0000, 1'b1);  // clamps high
    send_item(REQ_MAC, 12'd1, 32'h8000_0000, 1'b1);     // clamps low
    send_item(REQ_MAC, 12'd2, 32'hFFFF_FFFF, 1'b1);     // rounds down to -1 LSB
    send_item(REQ_MAC, 12'd1, 32'h7FFF_FFFF, 1'b0);
    send_item(REQ_MAC, 12'd0, 32'hFFFF_0000, 1'b0);
    send_item(REQ_EMPTY, 12'hFFF, 32'h1234_5678, 1'b1); // sums the pending two
    send_item(REQ_MAC, 12'd1, 32'h0000_0000, 1'b1);
    settle();
  endtask

  // Column limit: length one, zero length (all bad), above the store, reset value
  task automatic test_column_range;
    write_vector_length(13'd1);
    send_item(REQ_MAC, 12'd0, 32'h0001_0000, 1'b0);
    send_item(REQ_MAC, 12'd1, 32'h0001_0000, 1'b1);    // flags the row
    send_item(REQ_MAC, 12'd0, 32'h0003_0000, 1'b1);    // flag cleared again
    send_item(REQ_MAC, 12'd4095, 32'h7FFF_FFFF, 1'b0);
    send_item(REQ_EMPTY, 12'd0, 32'd0, 1'b0);          // zero sum, still flagged
    write_vector_length(13'd0);
    send_item(REQ_MAC, 12'd0, 32'h0001_0000, 1'b1);
    send_item(REQ_EMPTY, 12'd0, 32'd0, 1'b0);
    write_vector_length(13'h1FFF);
    send_item(REQ_MAC, 12'd4095, 32'hFFFF_0000, 1'b1);
    write_vector_length(VLEN_RESET);
  endtask

  // Random rows across several vector lengths with varying idle rates
  task automatic test_random_stream;
    gap_pct   = 25;
    stall_pct = 25;
    for (int k = 0; k < 30; k++)
      load_entry(12'($urandom_range(4095)), random_q16(), 1'b0);
    stream_rows(120);
    write_vector_length(13'($urandom_range(1, 4095)));
    gap_pct   = 0;
    stall_pct = 40;
    stream_rows(120);
    write_vector_length(13'($urandom_range(2, 24)));
    gap_pct   = 40;
    stall_pct = 0;
    for (int k = 0; k < 8; k++)
      load_entry(12'($urandom_range(stim_length - 1)), random_q16(), 1'b0);
    stream_rows(100);
    write_vector_length(13'h1FFF);
    gap_pct   = 15;
    stall_pct = 15;
    stream_rows(100);
    write_vector_length(VLEN_RESET);
  endtask

  // Back-to-back traffic with both sides always ready
  task automatic test_unthrottled_stream;
    write_vector_length(13'($urandom_range(1, 4095)));
    quiet = 1'b1;
    stream_rows(100);
    settle();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = REQ_LOAD;
    in_tlast      = 1'b0;
    row_acc       = 0;
    acc_saturated = 1'b0;
    row_bad       = 1'b0;
    rows_done     = '0;
    model_length  = VLEN_RESET;
    stim_length   = VLEN_RESET;
    gap_pct       = 20;
    stall_pct     = 20;
    quiet         = 1'b0;
    errors        = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_requests();
    test_column_range();
    test_random_stream();
    test_unthrottled_stream();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/csrmv_pkg.sv
hdl/csrmv_front.sv
hdl/csrmv_fifo.sv
hdl/csrmv_back.sv
hdl/sparse_csr_matrix_vector_multiply.sv
hdl/csrmv_checker.sv
bench/sparse_csr_matrix_vector_multiply_test.sv
